/* hw/rtl/stdp_pkg.sv */
// shared constants, types and the exp table of the stdp weight-update engine
package stdp_pkg;

    localparam int NEURONS      = 64;
    localparam int ID_BITS      = 6;
    localparam int IDX_BITS     = 7;
    localparam int TIME_BITS    = 16;
    localparam int DELTA_GAIN   = 256;
    localparam int WIN_BITS     = 7;
    localparam int PARAM_BITS   = 15;
    localparam int DELTA_BITS   = 16;
    localparam int COUNT_BITS   = 32;
    localparam int DIV_BITS     = 24;
    localparam int DIV_CNT_BITS = 5;
    localparam int EXP_N_BITS   = 3;
    localparam int FRAC_BITS    = 31;

    localparam logic [28:0] E_INV_Q30      = 29'd395007542;
    localparam logic [DIV_BITS-1:0] EXP_ZERO_BELOW = 24'd1420;

    // register reset values
    localparam logic [WIN_BITS-1:0]   RST_PAIR_WINDOW = 7'd20;
    localparam logic [PARAM_BITS-1:0] RST_TAU         = 15'd5120;
    localparam logic [PARAM_BITS-1:0] RST_AMP         = 15'd256;
    localparam logic [PARAM_BITS-1:0] RST_LIMIT       = 15'd32767;

    typedef enum logic [1:0] {
        CMD_PRE   = 2'd0,
        CMD_POST  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        REG_LEARN_ENABLE = 3'd0,
        REG_PAIR_WINDOW  = 3'd1,
        REG_TAU_POT      = 3'd2,
        REG_TAU_DEP      = 3'd3,
        REG_AMP_POT      = 3'd4,
        REG_AMP_DEP      = 3'd5,
        REG_DELTA_LIMIT  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic                  learn_enable;
        logic [WIN_BITS-1:0]   pair_window;
        logic [PARAM_BITS-1:0] tau_pot;
        logic [PARAM_BITS-1:0] tau_dep;
        logic [PARAM_BITS-1:0] amp_pot;
        logic [PARAM_BITS-1:0] amp_dep;
        logic [PARAM_BITS-1:0] delta_limit;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic rd;
        logic div_init;
        logic div_step;
        logic exp_init;
        logic exp_step;
        logic mul;
        logic push;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic id_ok;
        logic sweep_done;
        logic pair_hit;
        logic div_done;
        logic exp_zero;
        logic exp_done;
        logic cand_nz;
        logic pend_valid;
        logic out_free;
    } dp_sts_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        update_count;
        logic [TIME_BITS-1:0]         event_time;
        logic signed [DELTA_BITS-1:0] weight_delta;
        logic [ID_BITS-1:0]           post_index;
        logic [ID_BITS-1:0]           pre_index;
    } result_t;

    typedef logic [FRAC_BITS-1:0] frac_lut_t [256];

    // exp(-f/256) in q1.30, nine-term taylor sum, worked out at elaboration
    function automatic frac_lut_t build_exp_frac_lut();
        frac_lut_t   lut;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        for (int f = 0; f < 256; f++) begin
            t    = 64'(f) << 22;
            term = 64'd1 << 30;
            sum  = term;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * t) >> 30) / 64'(k);
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            lut[f] = sum[FRAC_BITS-1:0];
        end
        return lut;
    endfunction

    localparam frac_lut_t EXP_FRAC_LUT = build_exp_frac_lut();

endpackage

/* hw/rtl/stdp_pair_weight_update.sv */
// top level of the pair-based stdp weight-update engine
// usage:
//  - s_ channel takes one command beat: s_tuser holds the command (pre spike,
//    post spike, clear), s_tdata the neuron and its spike time
//  - m_ channel gives one beat per nonzero weight update, in ascending order
//    of the swept neuron; m_tlast marks the final update caused by a spike
//  - registers are written through cfg_wr_en / cfg_index / cfg_wdata while
//    the engine is idle; learn_enable low holds spike beats off (s_tready low),
//    clear beats are still taken
// sequence:
//  - clear and ignored beats are handled in the idle state, with no sweep
//  - a spike sweeps all 64 stored times of the other side, reading and
//    checking each; a qualifying pair then runs the bit-serial divider, the
//    table look-up, the exp multiply loop and the amplitude product, and the
//    delta; a pair whose exp factor is zero stops after the divider
//  - each result of a run leaves only once the next nonzero result or the end
//    of the sweep is found, since the last flag is only known then
// reset: all stored times read as never, count zero, registers at defaults
// stall: a held m_ beat stops the sweep at the next result; no beat is lost
module stdp_pair_weight_update (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // spike_neuron[5:0], spike_time[21:6], zero fill
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pre_index[5:0], post_index[11:6],
                                   // weight_delta[27:12], event_time[43:28],
                                   // update_count[75:44], zero fill
    output logic        m_tlast,
    // register write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);

    stdp_pkg::cfg_t    cfg_reg;
    stdp_pkg::dp_cmd_t dp_cmd;
    stdp_pkg::dp_sts_t dp_sts;
    stdp_pkg::result_t out_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_enable <= 1'b0;
            cfg_reg.pair_window  <= stdp_pkg::RST_PAIR_WINDOW;
            cfg_reg.tau_pot      <= stdp_pkg::RST_TAU;
            cfg_reg.tau_dep      <= stdp_pkg::RST_TAU;
            cfg_reg.amp_pot      <= stdp_pkg::RST_AMP;
            cfg_reg.amp_dep      <= stdp_pkg::RST_AMP;
            cfg_reg.delta_limit  <= stdp_pkg::RST_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                stdp_pkg::REG_LEARN_ENABLE: cfg_reg.learn_enable <= cfg_wdata[0];
                stdp_pkg::REG_PAIR_WINDOW:  cfg_reg.pair_window  <= cfg_wdata[6:0];
                stdp_pkg::REG_TAU_POT:      cfg_reg.tau_pot      <= cfg_wdata;
                stdp_pkg::REG_TAU_DEP:      cfg_reg.tau_dep      <= cfg_wdata;
                stdp_pkg::REG_AMP_POT:      cfg_reg.amp_pot      <= cfg_wdata;
                stdp_pkg::REG_AMP_DEP:      cfg_reg.amp_dep      <= cfg_wdata;
                stdp_pkg::REG_DELTA_LIMIT:  cfg_reg.delta_limit  <= cfg_wdata;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    stdp_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_cmd       (s_tuser),
        .learn_enable (cfg_reg.learn_enable),
        .in_ready     (s_tready),
        .dp_cmd       (dp_cmd),
        .dp_sts       (dp_sts)
    );

    stdp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts),
        .cfg       (cfg_reg),
        .in_cmd    (s_tuser),
        .in_id     (s_tdata[5:0]),
        .in_time   (s_tdata[21:6]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .out_last  (m_tlast)
    );

    // result beat packing, first field lowest
    assign m_tdata = {4'b0, out_data};

    // spike beats only go in while learning is on
    a_no_spike_when_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != stdp_pkg::CMD_CLEAR)) |-> cfg_reg.learn_enable)
        else $error("spike beat taken with learning disabled");

    // a result held from an earlier pair never survives into a new command
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_sts.pend_valid)
        else $error("pending result left over while taking a new beat");

    // the output register is only reloaded when its beat is gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ((dp_cmd.push && dp_sts.pend_valid) || dp_cmd.flush) |-> (!m_tvalid || m_tready))
        else $error("output beat overwritten before it was taken");

    // a flush always closes a run with the last flag
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.flush |=> (m_tvalid && m_tlast))
        else $error("end of run not marked");

endmodule

/* hw/rtl/stdp_ctrl.sv */
// controller state machine of the stdp weight-update engine
module stdp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [1:0]         in_cmd,
    input  logic               learn_enable,
    output logic               in_ready,
    output stdp_pkg::dp_cmd_t  dp_cmd,
    input  stdp_pkg::dp_sts_t  dp_sts
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_EXPI  = 8'b0001_0000,
        ST_EXPN  = 8'b0010_0000,
        ST_PUSH  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = (state_reg == ST_IDLE) &&
                     (learn_enable || (in_cmd == stdp_pkg::CMD_CLEAR));
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    if (in_cmd == stdp_pkg::CMD_CLEAR) begin
                        dp_cmd.clear = 1'b1;
                    end else if (((in_cmd == stdp_pkg::CMD_PRE) ||
                                  (in_cmd == stdp_pkg::CMD_POST)) && dp_sts.id_ok) begin
                        dp_cmd.start = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (dp_sts.sweep_done) begin
                    state_next = ST_FLUSH;
                end else begin
                    dp_cmd.rd  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (dp_sts.pair_hit) begin
                    dp_cmd.div_init = 1'b1;
                    state_next      = ST_DIV;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                dp_cmd.div_step = 1'b1;
                if (dp_sts.div_done) begin
                    state_next = ST_EXPI;
                end
            end
            ST_EXPI: begin
                if (dp_sts.exp_zero) begin
                    state_next = ST_READ;
                end else begin
                    dp_cmd.exp_init = 1'b1;
                    state_next      = ST_EXPN;
                end
            end
            ST_EXPN: begin
                if (dp_sts.exp_done) begin
                    dp_cmd.mul = 1'b1;
                    state_next = ST_PUSH;
                end else begin
                    dp_cmd.exp_step = 1'b1;
                end
            end
            ST_PUSH: begin
                if (!dp_sts.cand_nz) begin
                    state_next = ST_READ;
                end else if (!dp_sts.pend_valid || dp_sts.out_free) begin
                    dp_cmd.push = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!dp_sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (dp_sts.out_free) begin
                    dp_cmd.flush = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/stdp_dp.sv */
// datapath: spike-time stores, divider, exp unit, delta and result registers
module stdp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stdp_pkg::dp_cmd_t                   dp_cmd,
    output stdp_pkg::dp_sts_t                   dp_sts,
    input  stdp_pkg::cfg_t                      cfg,
    input  logic [1:0]                          in_cmd,
    input  logic [stdp_pkg::ID_BITS-1:0]        in_id,
    input  logic [stdp_pkg::TIME_BITS-1:0]      in_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output stdp_pkg::result_t                   out_data,
    output logic                                out_last
);

    localparam int NB = stdp_pkg::NEURONS;
    localparam int TB = stdp_pkg::TIME_BITS;
    localparam int IB = stdp_pkg::ID_BITS;
    localparam int PB = stdp_pkg::PARAM_BITS;
    localparam int DB = stdp_pkg::DIV_BITS;

    // time stores
    logic [TB-1:0] pre_mem  [NB];
    logic [TB-1:0] post_mem [NB];
    logic [NB-1:0] pre_vld_reg;
    logic [NB-1:0] post_vld_reg;

    // event being swept
    logic          dep_reg;
    logic [IB-1:0] ev_id_reg;
    logic [TB-1:0] ev_time_reg;
    logic [stdp_pkg::IDX_BITS-1:0] idx_reg;
    logic [IB-1:0] rd_idx_reg;
    logic [TB-1:0] rd_time_reg;
    logic          rd_vld_reg;

    // divider
    logic [DB-1:0] num_reg;
    logic [DB-1:0] quo_reg;
    logic [PB-1:0] rem_reg;
    logic [stdp_pkg::DIV_CNT_BITS-1:0] div_cnt_reg;

    // exp and product
    logic [stdp_pkg::FRAC_BITS-1:0]  v_reg;
    logic [stdp_pkg::EXP_N_BITS-1:0] n_reg;
    logic [23:0] m_reg;

    // pending and output
    logic                    pend_valid_reg;
    stdp_pkg::result_t       pend_reg;
    logic                    out_valid_reg;
    stdp_pkg::result_t       out_reg;
    logic                    out_last_reg;
    logic [stdp_pkg::COUNT_BITS-1:0] cnt_reg;
    logic [stdp_pkg::COUNT_BITS-1:0] cnt_next;

    logic [TB:0]   dt_full;
    logic [PB-1:0] tau_sel;
    logic [PB-1:0] amp_sel;
    logic [PB:0]   rem_sh;
    logic          rem_ge;
    logic [59:0]   exp_prod;
    logic [31:0]   pot_w;
    logic [31:0]   dep_c;
    logic [31:0]   dep_w;
    logic [31:0]   mag;
    logic [PB-1:0] cand_mag;
    logic signed [stdp_pkg::DELTA_BITS-1:0] cand_delta;
    logic          out_free;

    assign dt_full  = {1'b0, ev_time_reg} - {1'b0, rd_time_reg};
    assign tau_sel  = dep_reg ? cfg.tau_dep : cfg.tau_pot;
    assign amp_sel  = dep_reg ? cfg.amp_dep : cfg.amp_pot;
    assign rem_sh   = {rem_reg, num_reg[DB-1]};
    assign rem_ge   = rem_sh >= {1'b0, tau_sel};
    assign exp_prod = 60'(v_reg) * 60'(stdp_pkg::E_INV_Q30);

    // truncating scale for potentiation, rounding up for depression
    always_comb begin
        pot_w = (32'(m_reg[23:8]) * 32'(stdp_pkg::DELTA_GAIN)) >> 8;
        dep_c = (32'(m_reg) + 32'd255) >> 8;
        dep_w = (dep_c * 32'(stdp_pkg::DELTA_GAIN) + 32'd255) >> 8;
        mag   = dep_reg ? dep_w : pot_w;
        if (mag > 32'(cfg.delta_limit)) begin
            cand_mag = cfg.delta_limit;
        end else begin
            cand_mag = mag[PB-1:0];
        end
        if (dep_reg) begin
            cand_delta = -$signed({1'b0, cand_mag});
        end else begin
            cand_delta = $signed({1'b0, cand_mag});
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign cnt_next = cnt_reg + 32'd1;

    always_comb begin
        dp_sts.id_ok      = 7'(in_id) < 7'(NB);
        dp_sts.sweep_done = idx_reg == 7'(NB);
        dp_sts.pair_hit   = rd_vld_reg && (rd_time_reg != '0) && !dt_full[TB] &&
                            (dt_full != '0) && (dt_full < (TB+1)'(cfg.pair_window));
        dp_sts.div_done   = div_cnt_reg == 5'(DB - 1);
        dp_sts.exp_zero   = (tau_sel == '0) || (quo_reg > stdp_pkg::EXP_ZERO_BELOW);
        dp_sts.exp_done   = n_reg == '0;
        dp_sts.cand_nz    = cand_mag != '0;
        dp_sts.pend_valid = pend_valid_reg;
        dp_sts.out_free   = out_free;
    end

    // store writes and sweep reads
    always_ff @(posedge aclk) begin
        if (dp_cmd.start) begin
            if (in_cmd == stdp_pkg::CMD_PRE) begin
                pre_mem[in_id] <= in_time;
            end else begin
                post_mem[in_id] <= in_time;
            end
        end
        if (dp_cmd.rd) begin
            rd_time_reg <= dep_reg ? post_mem[idx_reg[IB-1:0]] : pre_mem[idx_reg[IB-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg    <= '0;
            post_vld_reg   <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end else begin
            if (dp_cmd.clear) begin
                pre_vld_reg  <= '0;
                post_vld_reg <= '0;
                cnt_reg      <= '0;
            end
            if (dp_cmd.start) begin
                idx_reg <= '0;
                if (in_cmd == stdp_pkg::CMD_PRE) begin
                    pre_vld_reg[in_id] <= 1'b1;
                end else begin
                    post_vld_reg[in_id] <= 1'b1;
                end
            end
            if (dp_cmd.rd) begin
                idx_reg    <= idx_reg + 7'd1;
                rd_vld_reg <= dep_reg ? post_vld_reg[idx_reg[IB-1:0]]
                                      : pre_vld_reg[idx_reg[IB-1:0]];
            end
            if (dp_cmd.push) begin
                cnt_reg        <= cnt_next;
                pend_valid_reg <= 1'b1;
            end else if (dp_cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((dp_cmd.push && pend_valid_reg) || dp_cmd.flush) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic and payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.start) begin
            dep_reg     <= in_cmd == stdp_pkg::CMD_PRE;
            ev_id_reg   <= in_id;
            ev_time_reg <= in_time;
        end
        if (dp_cmd.rd) begin
            rd_idx_reg <= idx_reg[IB-1:0];
        end
        if (dp_cmd.div_init) begin
            num_reg     <= {1'b0, dt_full[6:0], 16'b0} + DB'(tau_sel) - 24'd1;
            quo_reg     <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (dp_cmd.div_step) begin
            rem_reg     <= rem_ge ? PB'(rem_sh - {1'b0, tau_sel}) : rem_sh[PB-1:0];
            quo_reg     <= {quo_reg[DB-2:0], rem_ge};
            num_reg     <= {num_reg[DB-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
        if (dp_cmd.exp_init) begin
            v_reg <= stdp_pkg::EXP_FRAC_LUT[quo_reg[7:0]];
            n_reg <= quo_reg[10:8];
        end else if (dp_cmd.exp_step) begin
            v_reg <= {1'b0, exp_prod[59:30]};
            n_reg <= n_reg - 3'd1;
        end
        if (dp_cmd.mul) begin
            m_reg <= 24'(amp_sel) * 24'(v_reg[30:22]);
        end
        if (dp_cmd.push) begin
            pend_reg.pre_index    <= dep_reg ? ev_id_reg : rd_idx_reg;
            pend_reg.post_index   <= dep_reg ? rd_idx_reg : ev_id_reg;
            pend_reg.weight_delta <= cand_delta;
            pend_reg.event_time   <= ev_time_reg;
            pend_reg.update_count <= cnt_next;
        end
        if ((dp_cmd.push && pend_valid_reg) || dp_cmd.flush) begin
            out_reg      <= pend_reg;
            out_last_reg <= dp_cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_last  = out_last_reg;

endmodule
